[hdl/fwid_pkg.sv]
// shared constants, payload types and controller/datapath interface structs
package fwid_pkg;

    // string buffer sizing
    localparam int unsigned MODEL_BUF     = 16;
    localparam int unsigned VERSION_BUF   = 16;
    localparam int unsigned MODEL_MAX_LEN = 10;

    localparam int unsigned MAGIC_LEN     = 6;
    localparam int unsigned MAGIC_W       = 8 * MAGIC_LEN;
    localparam logic [MAGIC_W-1:0] MAGIC_RESET = 48'h4B4346574944;

    localparam int unsigned VER_MAX_LEN   = VERSION_BUF - 1;
    localparam int unsigned MODEL_OUT_LIM =
        (MODEL_MAX_LEN < MODEL_BUF - 1) ? MODEL_MAX_LEN : MODEL_BUF - 1;
    localparam int unsigned FLD_MAX =
        (MODEL_MAX_LEN > VER_MAX_LEN) ? MODEL_MAX_LEN : VER_MAX_LEN;
    localparam int unsigned POS_MAX = (FLD_MAX > MAGIC_LEN) ? FLD_MAX : MAGIC_LEN;

    localparam int unsigned POS_W = $clog2(POS_MAX + 1);
    localparam int unsigned LEN_W = $clog2(FLD_MAX + 1);
    localparam int unsigned MC_W  = $clog2(MODEL_MAX_LEN + 1);
    localparam int unsigned VC_W  = $clog2(VER_MAX_LEN + 1);
    localparam int unsigned MI_W  = (MODEL_MAX_LEN > 1) ? $clog2(MODEL_MAX_LEN) : 1;
    localparam int unsigned VI_W  = (VER_MAX_LEN > 1) ? $clog2(VER_MAX_LEN) : 1;
    localparam int unsigned DI_W  = (MC_W > VC_W) ? MC_W : VC_W;

    // field tags
    localparam logic [7:0] TAG_MODEL   = 8'h01;
    localparam logic [7:0] TAG_VERSION = 8'h02;

    // result kinds
    localparam logic [1:0] KIND_MODEL   = 2'd0;
    localparam logic [1:0] KIND_VERSION = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_MAGIC = 2'd2;
    localparam logic [1:0] ST_FIELD = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] char_value;
        logic [1:0] status_code;
        logic       run_end;
    } t_out_item;

    typedef struct packed {
        logic       magic_step;
        logic       len_load;
        logic       model_step;
        logic       ver_step;
        logic       clear;
        logic       drain_reset;
        logic       emit_model;
        logic       emit_ver;
        logic       load_status;
        logic [1:0] status_code;
    } t_dp_cmd;

    typedef struct packed {
        logic magic_end;
        logic magic_bad;
        logic tag1_ok;
        logic tag2_ok;
        logic len1_ok;
        logic len2_ok;
        logic field_end;
        logic model_left;
        logic ver_left;
        logic out_room;
    } t_dp_status;

endpackage

[hdl/fwid_datapath.sv]
// parse counters, string stores and output register
module fwid_datapath import fwid_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [7:0]         i_data_byte,
    input  logic [MAGIC_W-1:0] i_magic_word,
    input  logic               i_out_ready,
    output t_dp_status         o_status,
    output logic               o_out_valid,
    output t_out_item          o_out_item
);

    logic [POS_W-1:0] r_pos;
    logic             r_mismatch;
    logic [LEN_W-1:0] r_len;
    logic [MC_W-1:0]  r_model_count;
    logic [VC_W-1:0]  r_ver_count;
    logic             r_nul_seen;
    logic [DI_W-1:0]  r_drain_idx;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [7:0] r_model_store [MODEL_MAX_LEN];
    logic [7:0] r_ver_store   [VER_MAX_LEN];

    logic [7:0]   magic_byte;
    logic         byte_ne;
    logic [POS_W:0] pos_inc;
    logic         nul_now;
    logic         out_room;

    always_comb begin
        magic_byte = '0;
        for (int k = 0; k < MAGIC_LEN; k++) begin
            if (r_pos == POS_W'(k)) begin
                magic_byte = i_magic_word[8*(MAGIC_LEN-1-k) +: 8];
            end
        end
    end

    assign byte_ne  = (magic_byte != i_data_byte);
    assign pos_inc  = {1'b0, r_pos} + 1'b1;
    assign nul_now  = r_nul_seen || (i_data_byte == 8'd0);
    assign out_room = !r_out_valid || i_out_ready;

    assign o_status.magic_end  = (r_pos == POS_W'(MAGIC_LEN - 1));
    assign o_status.magic_bad  = r_mismatch || byte_ne;
    assign o_status.tag1_ok    = (i_data_byte == TAG_MODEL);
    assign o_status.tag2_ok    = (i_data_byte == TAG_VERSION);
    assign o_status.len1_ok    = (i_data_byte != 8'd0) && (i_data_byte <= 8'(MODEL_MAX_LEN));
    assign o_status.len2_ok    = (i_data_byte != 8'd0) && (i_data_byte <= 8'(VER_MAX_LEN));
    assign o_status.field_end  = (pos_inc >= (POS_W+1)'(r_len));
    assign o_status.model_left = (DI_W'(r_model_count) > r_drain_idx)
                               && (r_drain_idx < DI_W'(MODEL_OUT_LIM));
    assign o_status.ver_left   = (DI_W'(r_ver_count) > r_drain_idx);
    assign o_status.out_room   = out_room;

    // string stores, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.model_step && !nul_now && (r_model_count < MC_W'(MODEL_MAX_LEN))) begin
            r_model_store[r_model_count[MI_W-1:0]] <= i_data_byte;
        end
        if (i_cmd.ver_step && !nul_now && (r_ver_count < VC_W'(VER_MAX_LEN))) begin
            r_ver_store[r_ver_count[VI_W-1:0]] <= i_data_byte;
        end
    end

    // parse counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pos         <= '0;
            r_mismatch    <= 1'b0;
            r_len         <= '0;
            r_model_count <= '0;
            r_ver_count   <= '0;
            r_nul_seen    <= 1'b0;
        end else begin
            if (i_cmd.magic_step) begin
                r_mismatch <= r_mismatch || byte_ne;
                r_pos      <= o_status.magic_end ? '0 : pos_inc[POS_W-1:0];
            end
            if (i_cmd.len_load) begin
                r_len      <= LEN_W'(i_data_byte);
                r_pos      <= '0;
                r_nul_seen <= 1'b0;
            end
            if (i_cmd.model_step || i_cmd.ver_step) begin
                r_nul_seen <= o_status.field_end ? 1'b0 : nul_now;
                r_pos      <= o_status.field_end ? '0 : pos_inc[POS_W-1:0];
            end
            if (i_cmd.model_step && !nul_now && (r_model_count < MC_W'(MODEL_MAX_LEN))) begin
                r_model_count <= r_model_count + 1'b1;
            end
            if (i_cmd.ver_step && !nul_now && (r_ver_count < VC_W'(VER_MAX_LEN))) begin
                r_ver_count <= r_ver_count + 1'b1;
            end
        end
    end

    // drain index walks the stores one character a cycle while the output register has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.drain_reset) begin
            r_drain_idx <= '0;
        end else if (i_cmd.emit_model || i_cmd.emit_ver) begin
            r_drain_idx <= r_drain_idx + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_status || i_cmd.emit_model || i_cmd.emit_ver) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_status) begin
            r_out_item.item_kind   <= KIND_STATUS;
            r_out_item.char_value  <= 8'd0;
            r_out_item.status_code <= i_cmd.status_code;
            r_out_item.run_end     <= 1'b1;
        end else if (i_cmd.emit_model) begin
            r_out_item.item_kind   <= KIND_MODEL;
            r_out_item.char_value  <= r_model_store[r_drain_idx[MI_W-1:0]];
            r_out_item.status_code <= ST_OK;
            r_out_item.run_end     <= 1'b0;
        end else if (i_cmd.emit_ver) begin
            r_out_item.item_kind   <= KIND_VERSION;
            r_out_item.char_value  <= r_ver_store[r_drain_idx[VI_W-1:0]];
            r_out_item.status_code <= ST_OK;
            r_out_item.run_end     <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[hdl/fwid_controller.sv]
// parse and drain state machine
module fwid_controller import fwid_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_final_byte,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_MAGIC,
        S_TAG1,
        S_LEN1,
        S_MODEL,
        S_TAG2,
        S_LEN2,
        S_VERSION,
        S_SKIP,
        S_DRAIN_M,
        S_DRAIN_V,
        S_STATUS
    } t_state;

    t_state r_state, n_state;
    logic   r_final, n_final;
    logic   parsing;
    logic   fire;
    logic   done;
    logic   go_drain;
    logic [1:0] code;

    assign parsing = (r_state != S_DRAIN_M) && (r_state != S_DRAIN_V)
                   && (r_state != S_STATUS);
    assign o_in_ready = parsing && i_status.out_room;
    assign fire = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_final  = r_final;
        o_cmd    = '0;
        done     = 1'b0;
        go_drain = 1'b0;
        code     = ST_OK;

        unique case (r_state)
            S_MAGIC: begin
                if (fire) begin
                    o_cmd.magic_step = 1'b1;
                    if (i_status.magic_end) begin
                        if (i_status.magic_bad) begin
                            done = 1'b1;
                            code = ST_MAGIC;
                        end else begin
                            n_state = S_TAG1;
                        end
                    end else if (i_final_byte) begin
                        done = 1'b1;
                        code = ST_TRUNC;
                    end
                end
            end
            S_TAG1: begin
                if (fire) begin
                    if (!i_status.tag1_ok) begin
                        done = 1'b1;
                        code = ST_FIELD;
                    end else begin
                        n_state = S_LEN1;
                    end
                end
            end
            S_TAG2: begin
                if (fire) begin
                    if (!i_status.tag2_ok) begin
                        done = 1'b1;
                        code = ST_FIELD;
                    end else begin
                        n_state = S_LEN2;
                    end
                end
            end
            S_LEN1: begin
                if (fire) begin
                    if (!i_status.len1_ok) begin
                        done = 1'b1;
                        code = ST_FIELD;
                    end else begin
                        o_cmd.len_load = 1'b1;
                        n_state = S_MODEL;
                    end
                end
            end
            S_LEN2: begin
                if (fire) begin
                    if (!i_status.len2_ok) begin
                        done = 1'b1;
                        code = ST_FIELD;
                    end else begin
                        o_cmd.len_load = 1'b1;
                        n_state = S_VERSION;
                    end
                end
            end
            S_MODEL: begin
                if (fire) begin
                    o_cmd.model_step = 1'b1;
                    if (i_status.field_end) begin
                        n_state = S_TAG2;
                    end
                end
            end
            S_VERSION: begin
                if (fire) begin
                    o_cmd.ver_step = 1'b1;
                    if (i_status.field_end) begin
                        go_drain = 1'b1;
                    end
                end
            end
            S_SKIP: begin
            end
            S_DRAIN_M: begin
                if (!i_status.model_left) begin
                    o_cmd.drain_reset = 1'b1;
                    n_state = S_DRAIN_V;
                end else if (i_status.out_room) begin
                    o_cmd.emit_model = 1'b1;
                end
            end
            S_DRAIN_V: begin
                if (!i_status.ver_left) begin
                    n_state = S_STATUS;
                end else if (i_status.out_room) begin
                    o_cmd.emit_ver = 1'b1;
                end
            end
            S_STATUS: begin
                if (i_status.out_room) begin
                    o_cmd.load_status = 1'b1;
                    o_cmd.status_code = ST_OK;
                    if (r_final) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_MAGIC;
                    end else begin
                        n_state = S_SKIP;
                    end
                end
            end
            default: begin
                n_state = S_MAGIC;
            end
        endcase

        // common end-of-byte handling for the parse states
        if (fire) begin
            if (!done && !go_drain && i_final_byte && (r_state != S_SKIP)) begin
                done = 1'b1;
                code = ST_FIELD;
            end
            if (done) begin
                o_cmd.load_status = 1'b1;
                o_cmd.status_code = code;
            end
            if (go_drain) begin
                o_cmd.drain_reset = 1'b1;
                n_final = i_final_byte;
                n_state = S_DRAIN_M;
            end else if (i_final_byte) begin
                o_cmd.clear = 1'b1;
                n_state = S_MAGIC;
            end else if (done) begin
                n_state = S_SKIP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_MAGIC;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

endmodule

[hdl/firmware_id_tlv_parser_unit.sv]
// top level: configuration register, controller and datapath
// a status that a byte transfer raises is in the output register in the next cycle
// throughput: one byte per cycle in the parse states while the output register has room
// an ok run holds off input while model, version and status items drain, one a cycle while output has room
// reset: synchronous active-low i_rst_n clears parse state and output valid, magic word to default
// string stores are not reset; every entry is written before it is read
module firmware_id_tlv_parser_unit import fwid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [MAGIC_W-1:0] r_magic_word;
    logic               cfg_wr;
    logic               magic_sel;
    t_dp_cmd            cmd;
    t_dp_status         dp_status;

    // magic word register sits at byte address 0, low address bits ignored
    assign pready    = 1'b1;
    assign magic_sel = (paddr[3] == 1'b0);
    assign cfg_wr    = psel && penable && pwrite && pready && magic_sel;
    assign prdata    = magic_sel ? {{(64-MAGIC_W){1'b0}}, r_magic_word} : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word <= MAGIC_RESET;
        end else if (cfg_wr) begin
            r_magic_word <= pwdata[MAGIC_W-1:0];
        end
    end

    // controller decides per byte transfer, datapath holds counters and strings
    fwid_controller u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_byte (i_in_item.final_byte),
        .i_status     (dp_status),
        .o_in_ready   (o_in_ready),
        .o_cmd        (cmd)
    );

    fwid_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_data_byte  (i_in_item.data_byte),
        .i_magic_word (r_magic_word),
        .i_out_ready  (i_out_ready),
        .o_status     (dp_status),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item)
    );

endmodule
